// ===== hw/rtl/oal_pkg.sv =====
// shared constants, request/result types and helpers for the ordered array list engine
package oal_pkg;

    // list geometry
    localparam int DEPTH = 256;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMPW  = (CW > 9) ? CW : 9;

    // match scan geometry: one group of entries examined per cycle
    localparam int GRP   = 16;
    localparam int GRPW  = $clog2(GRP);
    localparam int NGRP  = (DEPTH + GRP - 1) / GRP;
    localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int MW    = NGRP * GRP;

    // operation codes
    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_DELETE = 3'd1;
    localparam logic [2:0] MODE_FIND   = 3'd2;
    localparam logic [2:0] MODE_CLEAR  = 3'd3;
    localparam logic [2:0] MODE_ADDU   = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_RANGE    = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic [8:0]         position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] found_position;
        logic [8:0] count;
        logic       is_empty;
    } t_res;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic               shift_up;
        logic               shift_down;
        logic [CMPW-1:0]    pos;
        logic [CMPW-1:0]    count;
        logic signed [31:0] value;
    } t_cell_ctrl;

    // lowest set bit of one group
    function automatic logic [GRPW-1:0] first_set(input logic [GRP-1:0] bits);
        logic [GRPW-1:0] r;
        r = '0;
        for (int k = GRP - 1; k >= 0; k--) begin
            if (bits[k]) begin
                r = GRPW'(k);
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ordered_array_list_engine_unit.sv =====
// top level of the ordered array list engine: control, match scan and result register
//
//  channel   direction  signals                   transfer
//  request   in         start, busy, i_req        start high and busy low at a clock edge
//  result    out        o_strobe, o_res           o_strobe high for one cycle, always taken
//
// insert, delete, clear and unused modes finish in the accept cycle; a new request
// may follow in the next cycle and the result strobes in the cycle after acceptance.
// find and add-unique register the match vector at acceptance; with busy high it is walked
// one group of 16 entries per cycle to the first hit or the last of NGRP (16 at 256 entries).
// reset is synchronous, active low; it empties the list, entry contents are kept.
// the receiver cannot stall, so each result is shown for exactly one cycle.
module ordered_array_list_engine_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  oal_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output oal_pkg::t_res o_res
);
    import oal_pkg::*;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [2:0]         r_mode, n_mode;
    logic signed [31:0] r_value, n_value;
    logic [MW-1:0]      r_match, n_match;
    logic [GW-1:0]      r_grp, n_grp;
    logic               r_strobe, n_strobe;
    t_res               r_res, n_res;

    t_cell_ctrl         w_ctrl;
    logic [DEPTH-1:0]   w_match;
    logic               w_accept;
    logic               w_full;
    logic [CMPW-1:0]    w_count_x;
    logic [CMPW-1:0]    w_pos_x;
    logic [CMPW-1:0]    w_ncount_x;
    logic [CMPW-1:0]    w_hit;
    logic [1:0]         w_status;
    logic [GRP-1:0]     w_grp_bits;
    logic               w_grp_hit;
    logic               w_last_grp;

    assign w_accept   = start && (r_state == ST_IDLE);
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_count_x  = CMPW'(r_count);
    assign w_pos_x    = CMPW'(i_req.position);
    assign w_grp_bits = r_match[GRP-1:0];
    assign w_grp_hit  = |w_grp_bits;
    assign w_last_grp = (r_grp == GW'(NGRP - 1));

    oal_row u_row (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .o_match (w_match)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && ((i_req.mode == MODE_FIND) || (i_req.mode == MODE_ADDU))) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_grp_hit || w_last_grp) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // cell control, count update and result
    always_comb begin
        w_ctrl.shift_up   = 1'b0;
        w_ctrl.shift_down = 1'b0;
        w_ctrl.pos        = w_pos_x;
        w_ctrl.count      = w_count_x;
        w_ctrl.value      = (r_state == ST_SCAN) ? r_value : i_req.value;
        n_count  = r_count;
        n_mode   = r_mode;
        n_value  = r_value;
        n_match  = r_match;
        n_grp    = r_grp;
        n_strobe = 1'b0;
        w_status = STAT_OK;
        w_hit    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_strobe = 1'b1;
                    unique case (i_req.mode)
                        MODE_INSERT: begin
                            if (w_full) begin
                                w_status = STAT_FULL;
                            end else if (w_pos_x > w_count_x) begin
                                w_status = STAT_RANGE;
                            end else begin
                                w_ctrl.shift_up = 1'b1;
                                n_count         = r_count + CW'(1);
                            end
                        end
                        MODE_DELETE: begin
                            if (w_pos_x >= w_count_x) begin
                                w_status = STAT_RANGE;
                            end else begin
                                w_ctrl.shift_down = 1'b1;
                                n_count           = r_count - CW'(1);
                            end
                        end
                        MODE_FIND, MODE_ADDU: begin
                            // capture the compare of every live entry, then scan it
                            n_strobe = 1'b0;
                            n_match  = MW'(w_match);
                            n_grp    = '0;
                            n_mode   = i_req.mode;
                            n_value  = i_req.value;
                        end
                        MODE_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_match = r_match >> GRP;
                n_grp   = r_grp + GW'(1);
                if (w_grp_hit) begin
                    n_strobe = 1'b1;
                    if (r_mode == MODE_FIND) begin
                        w_hit = (CMPW'(r_grp) << GRPW) | CMPW'(first_set(w_grp_bits));
                    end
                end else if (w_last_grp) begin
                    n_strobe = 1'b1;
                    if (r_mode == MODE_FIND) begin
                        w_status = STAT_NOTFOUND;
                    end else if (w_full) begin
                        w_status = STAT_FULL;
                    end else begin
                        // absent value goes in at the front
                        w_ctrl.shift_up = 1'b1;
                        w_ctrl.pos      = '0;
                        n_count         = r_count + CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
        w_ncount_x           = CMPW'(n_count);
        n_res.status         = w_status;
        n_res.found_position = w_hit[7:0];
        n_res.count          = w_ncount_x[8:0];
        n_res.is_empty       = (n_count == '0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_value <= n_value;
        r_match <= n_match;
        r_grp   <= n_grp;
        r_res   <= n_res;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

`ifndef SYNTHESIS
    // a result never shows while a scan is still running
    a_no_result_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_strobe)
        else $error("result strobe during scan");

    // the list never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // insert, delete, clear and unused modes report in the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.mode != MODE_FIND) && (i_req.mode != MODE_ADDU))
        |=> o_strobe)
        else $error("missing result after single-cycle request");

    // a scan ends once its last group is reached
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && w_last_grp) |=> !busy)
        else $error("scan ran past the last group");
`endif

endmodule

// ===== hw/rtl/oal_cell.sv =====
// one list cell: holds one entry, shifts with its neighbors, compares against the key
module oal_cell (
    input  logic                    i_clk,
    input  logic [oal_pkg::CMPW-1:0] i_idx,
    input  oal_pkg::t_cell_ctrl     i_ctrl,
    input  logic signed [31:0]      i_prev,
    input  logic signed [31:0]      i_next,
    output logic signed [31:0]      o_value,
    output logic                    o_match
);
    import oal_pkg::*;

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    // shift up on insert and add-unique, down on delete
    always_comb begin
        n_value = r_value;
        priority if (i_ctrl.shift_up && (i_idx > i_ctrl.pos)) begin
            n_value = i_prev;
        end else if (i_ctrl.shift_up && (i_idx == i_ctrl.pos)) begin
            n_value = i_ctrl.value;
        end else if (i_ctrl.shift_down && (i_idx >= i_ctrl.pos)) begin
            n_value = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // only live entries can match
    assign o_match = (r_value == i_ctrl.value) && (i_idx < i_ctrl.count);
    assign o_value = r_value;

endmodule

// ===== hw/rtl/oal_row.sv =====
// row of list cells chained to their neighbors
module oal_row (
    input  logic                        i_clk,
    input  oal_pkg::t_cell_ctrl         i_ctrl,
    output logic [oal_pkg::DEPTH-1:0]   o_match
);
    import oal_pkg::*;

    logic signed [31:0] w_value [DEPTH];
    logic signed [31:0] w_prev  [DEPTH];
    logic signed [31:0] w_next  [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        // end cells take the key and their own value at the open ends
        if (g == 0) begin : g_first
            assign w_prev[g] = i_ctrl.value;
        end else begin : g_mid_prev
            assign w_prev[g] = w_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next[g] = w_value[g];
        end else begin : g_mid_next
            assign w_next[g] = w_value[g+1];
        end

        oal_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (CMPW'(g)),
            .i_ctrl  (i_ctrl),
            .i_prev  (w_prev[g]),
            .i_next  (w_next[g]),
            .o_value (w_value[g]),
            .o_match (o_match[g])
        );
    end

endmodule
